FILE: hdl/coap_pkg.sv
package coap_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  item_kind;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [2:0]  code_class;
        logic [4:0]  code_detail;
        logic [15:0] message_id;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  out_byte;
        logic [2:0]  error_code;
        logic        message_end;
    } out_item_t;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_TOKEN   = 3'd1;
    localparam logic [2:0] KIND_OPTHDR  = 3'd2;
    localparam logic [2:0] KIND_OPTVAL  = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;
    localparam logic [2:0] KIND_END     = 3'd6;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_VERSION   = 3'd1;
    localparam logic [2:0] ERR_TOKEN     = 3'd2;
    localparam logic [2:0] ERR_DELTA     = 3'd3;
    localparam logic [2:0] ERR_LENGTH    = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0]  NIB_EXT1       = 4'd13;
    localparam logic [3:0]  NIB_EXT2       = 4'd14;
    localparam logic [3:0]  NIB_RESERVED   = 4'd15;
    localparam logic [3:0]  MAX_TOKEN      = 4'd8;
    localparam logic [16:0] EXT2_BIAS      = 17'd269;

endpackage

FILE: hdl/coap_message_decoder_unit.sv
// CoAP message decoder.
// Input channel: push/full queue port carrying one datagram byte plus an
// end-of-datagram flag per transfer. Output channel: empty/pop queue port;
// the oldest result sits on result while empty is low.
// Each byte yields zero or one result (header, token byte, option header,
// option value byte, payload byte, error, or end-only marker).
// Throughput: one byte per cycle while the result queue has room. A byte
// passes the input queue, parse register and result queue to result.
// A two-entry input queue decouples the front from the parse stage; the
// parse stage only advances when the result queue has room for its slot,
// so a stalled receiver backs pressure up to full without losing bytes.
// Reset clears all queues and the parse state; the first byte after reset
// is taken as header byte 0.
module coap_message_decoder_unit #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  coap_pkg::in_item_t  data,
    output logic                full,
    input  logic                pop,
    output coap_pkg::out_item_t result,
    output logic                empty
);
    localparam int IW = $bits(coap_pkg::in_item_t);
    localparam int OW = $bits(coap_pkg::out_item_t);
    localparam int CW = $clog2(OUT_DEPTH + 2);

    logic               q_empty, q_pop;
    coap_pkg::in_item_t q_item;
    logic               p_valid;
    coap_pkg::out_item_t p_item;
    logic               o_full;
    logic [CW-1:0]      inflight_reg;
    logic               u_parse_done_none;
    logic               issued_reg;

    coap_fifo #(.WIDTH(IW), .DEPTH(2)) u_in_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data(data), .full(full),
        .rd_en(q_pop), .rd_data(q_item), .empty(q_empty)
    );

    // credit: a byte is popped only while reserved slots (in flight plus queued) are below depth
    logic [CW-1:0] occ;
    assign q_pop = !q_empty && (occ < CW'(OUT_DEPTH));

    coap_parser u_parse (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_pop), .in_item(q_item),
        .out_valid(p_valid), .out_item(p_item)
    );

    coap_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk(clk), .rst_n(rst_n),
        .wr_en(p_valid), .wr_data(p_item), .full(o_full),
        .rd_en(pop), .rd_data(result), .empty(empty)
    );

    // inflight_reg counts entries reserved: bytes popped to parser (worst case
    // one result each) not yet released by result pop or a no-result byte
    assign occ = inflight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + CW'(q_pop)
                          - CW'(pop && !empty)
                          - CW'(u_parse_done_none);
        end
    end

    // a parsed byte that made no result frees its reserved slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issued_reg <= 1'b0;
        end
        else
        begin
            issued_reg <= q_pop;
        end
    end
    assign u_parse_done_none = issued_reg && !p_valid;

    logic unused_full;
    assign unused_full = o_full;
endmodule

FILE: hdl/coap_fifo.sv
module coap_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
        end
    end
endmodule

FILE: hdl/coap_parser.sv
// Back end: byte-level CoAP parse state machine, one byte per cycle while in_valid is high.
module coap_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  coap_pkg::in_item_t  in_item,
    output logic                out_valid,
    output coap_pkg::out_item_t out_item
);
    typedef enum logic [3:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_TOKEN, PH_OPT, PH_D1, PH_D2H,
        PH_D2L, PH_L1, PH_L2H, PH_L2L, PH_VALUE, PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] hdr_reg, hdr_next;
    logic [3:0]  tok_reg, tok_next;
    logic [16:0] optnum_reg, optnum_next;
    logic [3:0]  lennib_reg, lennib_next;
    logic [7:0]  ext_reg, ext_next;
    logic [16:0] vleft_reg, vleft_next;
    logic        skip_reg, skip_next;

    logic [7:0]  b;
    logic        last;
    logic        have, err;
    logic [2:0]  ecode;
    coap_pkg::out_item_t res;
    logic [16:0] delta, len;
    // one spare bit: running number plus a two-byte extended delta can pass 2^17
    logic [17:0] nsum;
    logic        do_delta, do_len;

    assign b    = in_item.data_byte;
    assign last = in_item.last_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        tok_next    = tok_reg;
        optnum_next = optnum_reg;
        lennib_next = lennib_reg;
        ext_next    = ext_reg;
        vleft_next  = vleft_reg;
        skip_next   = skip_reg;
        res         = '0;
        have        = 1'b0;
        err         = 1'b0;
        ecode       = coap_pkg::ERR_NONE;
        delta       = '0;
        len         = '0;
        do_delta    = 1'b0;
        do_len      = 1'b0;
        nsum        = '0;

        if (skip_reg)
        begin
            if (last)
            begin
                have          = 1'b1;
                res.item_kind = coap_pkg::KIND_END;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    if (b[7:6] != 2'd1)
                    begin
                        err = 1'b1; ecode = coap_pkg::ERR_VERSION;
                    end
                    else if (b[3:0] > coap_pkg::MAX_TOKEN)
                    begin
                        err = 1'b1; ecode = coap_pkg::ERR_TOKEN;
                    end
                    else
                    begin
                        hdr_next   = {b, 16'd0};
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    hdr_next[15:8] = b;
                    phase_next     = PH_HDR2;
                end
                PH_HDR2:
                begin
                    hdr_next[7:0] = b;
                    phase_next    = PH_HDR3;
                end
                PH_HDR3:
                begin
                    have             = 1'b1;
                    res.item_kind    = coap_pkg::KIND_HEADER;
                    res.msg_type     = hdr_reg[21:20];
                    res.token_length = hdr_reg[19:16];
                    res.code_class   = hdr_reg[15:13];
                    res.code_detail  = hdr_reg[12:8];
                    res.message_id   = {hdr_reg[7:0], b};
                    tok_next         = hdr_reg[19:16];
                    phase_next       = (hdr_reg[19:16] != 4'd0) ? PH_TOKEN : PH_OPT;
                end
                PH_TOKEN:
                begin
                    have          = 1'b1;
                    res.item_kind = coap_pkg::KIND_TOKEN;
                    res.out_byte  = b;
                    tok_next      = tok_reg - 4'd1;
                    if (tok_reg == 4'd1)
                    begin
                        phase_next = PH_OPT;
                    end
                end
                PH_OPT:
                begin
                    if (b == coap_pkg::PAYLOAD_MARKER)
                    begin
                        if (last)
                        begin
                            err = 1'b1; ecode = coap_pkg::ERR_TRUNCATED;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else if (b[7:4] == coap_pkg::NIB_RESERVED)
                    begin
                        err = 1'b1; ecode = coap_pkg::ERR_DELTA;
                    end
                    else if (b[3:0] == coap_pkg::NIB_RESERVED)
                    begin
                        err = 1'b1; ecode = coap_pkg::ERR_LENGTH;
                    end
                    else
                    begin
                        lennib_next = b[3:0];
                        if (b[7:4] == coap_pkg::NIB_EXT1)
                        begin
                            phase_next = PH_D1;
                        end
                        else if (b[7:4] == coap_pkg::NIB_EXT2)
                        begin
                            phase_next = PH_D2H;
                        end
                        else
                        begin
                            do_delta = 1'b1;
                            delta    = {13'd0, b[7:4]};
                        end
                    end
                end
                PH_D1:
                begin
                    do_delta = 1'b1;
                    delta    = {9'd0, b} + 17'd13;
                end
                PH_D2H:
                begin
                    ext_next   = b;
                    phase_next = PH_D2L;
                end
                PH_D2L:
                begin
                    do_delta = 1'b1;
                    delta    = {1'b0, ext_reg, b} + coap_pkg::EXT2_BIAS;
                end
                PH_L1:
                begin
                    do_len = 1'b1;
                    len    = {9'd0, b} + 17'd13;
                end
                PH_L2H:
                begin
                    ext_next   = b;
                    phase_next = PH_L2L;
                end
                PH_L2L:
                begin
                    do_len = 1'b1;
                    len    = {1'b0, ext_reg, b} + coap_pkg::EXT2_BIAS;
                end
                PH_VALUE:
                begin
                    have          = 1'b1;
                    res.item_kind = coap_pkg::KIND_OPTVAL;
                    res.out_byte  = b;
                    vleft_next    = vleft_reg - 17'd1;
                    if (vleft_reg == 17'd1)
                    begin
                        phase_next = PH_OPT;
                    end
                end
                PH_PAYLOAD:
                begin
                    have          = 1'b1;
                    res.item_kind = coap_pkg::KIND_PAYLOAD;
                    res.out_byte  = b;
                end
                default: phase_next = PH_HDR0;
            endcase

            if (do_delta)
            begin
                nsum = {1'b0, optnum_reg} + {1'b0, delta};
                if (nsum[17:16] != 2'd0)
                begin
                    err = 1'b1; ecode = coap_pkg::ERR_LENGTH;
                end
                else
                begin
                    optnum_next = nsum[16:0];
                    if (lennib_next == coap_pkg::NIB_EXT1)
                    begin
                        phase_next = PH_L1;
                    end
                    else if (lennib_next == coap_pkg::NIB_EXT2)
                    begin
                        phase_next = PH_L2H;
                    end
                    else
                    begin
                        do_len = 1'b1;
                        len    = {13'd0, lennib_next};
                    end
                end
            end

            if (do_len)
            begin
                if (len[16])
                begin
                    err = 1'b1; ecode = coap_pkg::ERR_LENGTH;
                end
                else
                begin
                    have              = 1'b1;
                    res.item_kind     = coap_pkg::KIND_OPTHDR;
                    res.option_number = optnum_next[15:0];
                    res.option_length = len[15:0];
                    if (len == 17'd0)
                    begin
                        phase_next = PH_OPT;
                    end
                    else
                    begin
                        vleft_next = len;
                        phase_next = PH_VALUE;
                    end
                end
            end

            if (last && !err && phase_next != PH_OPT && phase_next != PH_PAYLOAD)
            begin
                err = 1'b1; ecode = coap_pkg::ERR_TRUNCATED;
            end
            if (err)
            begin
                have           = 1'b1;
                res            = '0;
                res.item_kind  = coap_pkg::KIND_ERROR;
                res.error_code = ecode;
                if (!last)
                begin
                    skip_next  = 1'b1;
                    phase_next = PH_HDR0;
                end
            end
        end

        if (last)
        begin
            if (!have)
            begin
                res.item_kind = coap_pkg::KIND_END;
                have          = 1'b1;
            end
            res.message_end = 1'b1;
            phase_next  = PH_HDR0;
            hdr_next    = '0;
            tok_next    = '0;
            optnum_next = '0;
            lennib_next = '0;
            ext_next    = '0;
            vleft_next  = '0;
            skip_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            hdr_reg    <= '0;
            tok_reg    <= '0;
            optnum_reg <= '0;
            lennib_reg <= '0;
            ext_reg    <= '0;
            vleft_reg  <= '0;
            skip_reg   <= 1'b0;
            out_valid  <= 1'b0;
            out_item   <= '0;
        end
        else
        begin
            out_valid <= in_valid && have;
            if (in_valid)
            begin
                phase_reg  <= phase_next;
                hdr_reg    <= hdr_next;
                tok_reg    <= tok_next;
                optnum_reg <= optnum_next;
                lennib_reg <= lennib_next;
                ext_reg    <= ext_next;
                vleft_reg  <= vleft_next;
                skip_reg   <= skip_next;
                out_item   <= res;
            end
        end
    end
endmodule

FILE: hdl/coap_checker.sv
module coap_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                full,
    input logic                pop,
    input logic                empty,
    input coap_pkg::out_item_t result
);
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.item_kind <= coap_pkg::KIND_END))
        else $error("bad kind");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.item_kind == coap_pkg::KIND_ERROR)
            |-> (result.error_code != coap_pkg::ERR_NONE))
        else $error("error without code");
    a_endonly: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.item_kind == coap_pkg::KIND_END) |-> result.message_end)
        else $error("end marker without end");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");
    // input backs up only behind a loaded result queue
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full while no result waiting");
endmodule

bind coap_message_decoder_unit coap_checker u_chk (
    .clk(clk), .rst_n(rst_n), .full(full),
    .pop(pop), .empty(empty), .result(result)
);

FILE: tb/sv/tb_coap_message_decoder_unit.sv
module tb_coap_message_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // parser phases of the predictor
    typedef enum logic [3:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_TOKEN, PH_OPT, PH_D1, PH_D2H,
        PH_D2L, PH_L1, PH_L2H, PH_L2L, PH_VALUE, PH_PAYLOAD
    } phase_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_BYTES = 372;

    logic                clk;
    logic                rst_n;
    logic                push;
    coap_pkg::in_item_t  data;
    logic                full;
    logic                pop;
    coap_pkg::out_item_t result;
    logic                empty;

    coap_message_decoder_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .data   (data),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    phase_t      ph;
    logic [23:0] hdr_hold;
    logic [3:0]  tok_left;
    int unsigned opt_num;
    logic [7:0]  nibbles;
    logic [7:0]  ext_hi;
    int unsigned val_left;
    logic        skipping;

    coap_pkg::out_item_t expected_results[$];
    int          fail_count;
    int          cycle_count;
    int          sent_count;

    // sender / receiver behavior, set by the main sequence
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_off;
    int          hold_cycles;

    function automatic void clear_parser();
        ph = PH_HDR0;
        hdr_hold = '0;
        tok_left = '0;
        opt_num = 0;
        nibbles = '0;
        ext_hi = '0;
        val_left = 0;
        skipping = 1'b0;
    endfunction

    // Decode one datagram byte; queue its result, if any.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        coap_pkg::out_item_t r;
        logic      have;
        logic      err;
        int unsigned dsum;
        int unsigned len;
        logic      len_ready;
        r = '0;
        have = 1'b0;
        err = 1'b0;
        len_ready = 1'b0;
        len = 0;
        dsum = 0;
        if (skipping)
        begin
            if (!last)
                return;
            r.item_kind = coap_pkg::KIND_END;
            have = 1'b1;
        end
        else
        begin
            case (ph)
                PH_HDR0:
                begin
                    if (b[7:6] != 2'd1)
                    begin
                        r.item_kind = coap_pkg::KIND_ERROR;
                        r.error_code = coap_pkg::ERR_VERSION; err = 1'b1;
                    end
                    else if (b[3:0] > coap_pkg::MAX_TOKEN)
                    begin
                        r.item_kind = coap_pkg::KIND_ERROR;
                        r.error_code = coap_pkg::ERR_TOKEN; err = 1'b1;
                    end
                    else
                    begin
                        hdr_hold = {b, 16'h0};
                        ph = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    hdr_hold[15:8] = b;
                    ph = PH_HDR2;
                end
                PH_HDR2:
                begin
                    hdr_hold[7:0] = b;
                    ph = PH_HDR3;
                end
                PH_HDR3:
                begin
                    r.item_kind = coap_pkg::KIND_HEADER;
                    r.msg_type = hdr_hold[21:20];
                    r.token_length = hdr_hold[19:16];
                    r.code_class = hdr_hold[15:13];
                    r.code_detail = hdr_hold[12:8];
                    r.message_id = {hdr_hold[7:0], b};
                    have = 1'b1;
                    tok_left = hdr_hold[19:16];
                    ph = (tok_left != 0) ? PH_TOKEN : PH_OPT;
                end
                PH_TOKEN:
                begin
                    r.item_kind = coap_pkg::KIND_TOKEN; r.out_byte = b; have = 1'b1;
                    tok_left = tok_left - 1'b1;
                    if (tok_left == 0)
                        ph = PH_OPT;
                end
                PH_OPT:
                begin
                    if (b == coap_pkg::PAYLOAD_MARKER)
                    begin
                        if (last)
                        begin
                            r.item_kind = coap_pkg::KIND_ERROR;
                            r.error_code = coap_pkg::ERR_TRUNCATED;
                            err = 1'b1;
                        end
                        else
                            ph = PH_PAYLOAD;
                    end
                    else if (b[7:4] == coap_pkg::NIB_RESERVED)
                    begin
                        r.item_kind = coap_pkg::KIND_ERROR;
                        r.error_code = coap_pkg::ERR_DELTA; err = 1'b1;
                    end
                    else if (b[3:0] == coap_pkg::NIB_RESERVED)
                    begin
                        r.item_kind = coap_pkg::KIND_ERROR;
                        r.error_code = coap_pkg::ERR_LENGTH; err = 1'b1;
                    end
                    else
                    begin
                        nibbles = b;
                        if (b[7:4] == coap_pkg::NIB_EXT1)
                            ph = PH_D1;
                        else if (b[7:4] == coap_pkg::NIB_EXT2)
                            ph = PH_D2H;
                        else
                            dsum = 1 + b[7:4];
                    end
                end
                PH_D1:  dsum = 1 + b + 13;
                PH_D2H:
                begin
                    ext_hi = b;
                    ph = PH_D2L;
                end
                PH_D2L: dsum = 1 + {ext_hi, b} + coap_pkg::EXT2_BIAS;
                PH_L1:
                begin
                    len = b + 13; len_ready = 1'b1;
                end
                PH_L2H:
                begin
                    ext_hi = b;
                    ph = PH_L2L;
                end
                PH_L2L:
                begin
                    len = {ext_hi, b} + coap_pkg::EXT2_BIAS; len_ready = 1'b1;
                end
                PH_VALUE:
                begin
                    r.item_kind = coap_pkg::KIND_OPTVAL; r.out_byte = b; have = 1'b1;
                    val_left--;
                    if (val_left == 0)
                        ph = PH_OPT;
                end
                default:
                begin
                    r.item_kind = coap_pkg::KIND_PAYLOAD; r.out_byte = b; have = 1'b1;
                end
            endcase
            // delta complete (dsum holds delta+1 so a zero delta still counts)
            if (dsum != 0)
            begin
                if (opt_num + dsum - 1 > 65535)
                begin
                    r.item_kind = coap_pkg::KIND_ERROR;
                    r.error_code = coap_pkg::ERR_LENGTH; err = 1'b1;
                end
                else
                begin
                    opt_num = opt_num + dsum - 1;
                    if (nibbles[3:0] == coap_pkg::NIB_EXT1)
                        ph = PH_L1;
                    else if (nibbles[3:0] == coap_pkg::NIB_EXT2)
                        ph = PH_L2H;
                    else
                    begin
                        len = nibbles[3:0]; len_ready = 1'b1;
                    end
                end
            end
            if (len_ready)
            begin
                if (len > 65535)
                begin
                    r.item_kind = coap_pkg::KIND_ERROR;
                    r.error_code = coap_pkg::ERR_LENGTH; err = 1'b1;
                end
                else
                begin
                    r.item_kind = coap_pkg::KIND_OPTHDR;
                    r.option_number = opt_num[15:0];
                    r.option_length = len[15:0];
                    have = 1'b1;
                    val_left = len;
                    ph = (len == 0) ? PH_OPT : PH_VALUE;
                end
            end
            if (last && !err && ph != PH_OPT && ph != PH_PAYLOAD)
            begin
                r = '0; r.item_kind = coap_pkg::KIND_ERROR;
                r.error_code = coap_pkg::ERR_TRUNCATED; err = 1'b1;
            end
            if (err)
            begin
                // error overrides whatever the byte would have given
                have = 1'b1;
                r.msg_type = '0; r.token_length = '0; r.code_class = '0; r.code_detail = '0;
                r.message_id = '0; r.option_number = '0; r.option_length = '0;
                r.out_byte = '0; r.item_kind = coap_pkg::KIND_ERROR;
                if (!last)
                begin
                    skipping = 1'b1;
                    ph = PH_HDR0;
                end
            end
        end
        if (last)
        begin
            if (!have)
            begin
                r = '0; r.item_kind = coap_pkg::KIND_END; have = 1'b1;
            end
            r.message_end = 1'b1;
            clear_parser();
        end
        if (have)
            expected_results.push_back(r);
    endfunction

    // Drive one byte; waits for acceptance. Sender idling happens here.
    // push stays high after the transfer; idle_sender drops it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_byte(b, last);
        sent_count++;
    endtask

    task automatic idle_sender();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_list(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Random datagram: mostly well-formed, sometimes noise bytes or damaged.
    task automatic send_random_datagram();
        logic [7:0] q[$];
        int         tl;
        int         nopt;
        int         d;
        int         l;
        int         kind;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            // noise: arbitrary bytes
            repeat ($urandom_range(1, 12))
                q.push_back(8'($urandom));
        end
        else
        begin
            tl = $urandom_range(8);
            q.push_back({2'd1, 2'($urandom), 4'(tl)});
            q.push_back(8'($urandom));
            q.push_back(8'($urandom));
            q.push_back(8'($urandom));
            repeat (tl)
                q.push_back(8'($urandom));
            nopt = $urandom_range(4);
            repeat (nopt)
            begin
                case ($urandom_range(5))
                    0: d = 13 + $urandom_range(255);
                    1: d = 269 + $urandom_range(65535);
                    default: d = $urandom_range(12);
                endcase
                l = ($urandom_range(9) == 0) ? 13 + $urandom_range(3)
                                             : $urandom_range(12);
                if ($urandom_range(30) == 0)
                    l = 269 + $urandom_range(1);
                q.push_back({(d >= 269) ? coap_pkg::NIB_EXT2 :
                             (d >= 13) ? coap_pkg::NIB_EXT1 : 4'(d),
                             (l >= 269) ? coap_pkg::NIB_EXT2 :
                             (l >= 13) ? coap_pkg::NIB_EXT1 : 4'(l)});
                if (d >= 269)
                begin
                    q.push_back(8'((d - 269) >> 8));
                    q.push_back(8'(d - 269));
                end
                else if (d >= 13)
                    q.push_back(8'(d - 13));
                if (l >= 269)
                begin
                    q.push_back(8'((l - 269) >> 8));
                    q.push_back(8'(l - 269));
                end
                else if (l >= 13)
                    q.push_back(8'(l - 13));
                repeat (l)
                    q.push_back(8'($urandom));
            end
            if ($urandom_range(1))
            begin
                q.push_back(coap_pkg::PAYLOAD_MARKER);
                repeat ($urandom_range(1, 6))
                    q.push_back(8'($urandom));
            end
            if (kind < 20)
                q = q[0:$urandom_range(q.size() - 1)];              // truncated
            else if (kind < 30)
                q[$urandom_range(q.size() - 1)] = 8'($urandom);   // corrupted
        end
        send_list(q);
    endtask

    // Receiver: random stalls plus a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_off && hold_cycles < 300)
        begin
            pop <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else
        begin
            pop <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
            if (!hold_off)
                hold_cycles <= 0;
        end
    end

    // Checker: compare each popped result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind %0d", result.item_kind);
                fail_count++;
            end
            else
            begin
                coap_pkg::out_item_t e;
                e = expected_results.pop_front();
                if (result.item_kind !== e.item_kind)
                    $error("item_kind exp %0d got %0d", e.item_kind, result.item_kind);
                if (result.msg_type !== e.msg_type)
                    $error("msg_type exp %0d got %0d", e.msg_type, result.msg_type);
                if (result.token_length !== e.token_length)
                    $error("token_length exp %0d got %0d", e.token_length, result.token_length);
                if (result.code_class !== e.code_class)
                    $error("code_class exp %0d got %0d", e.code_class, result.code_class);
                if (result.code_detail !== e.code_detail)
                    $error("code_detail exp %0d got %0d", e.code_detail, result.code_detail);
                if (result.message_id !== e.message_id)
                    $error("message_id exp %0d got %0d", e.message_id, result.message_id);
                if (result.option_number !== e.option_number)
                    $error("option_number exp %0d got %0d", e.option_number,
                           result.option_number);
                if (result.option_length !== e.option_length)
                    $error("option_length exp %0d got %0d", e.option_length,
                           result.option_length);
                if (result.out_byte !== e.out_byte)
                    $error("out_byte exp %0d got %0d", e.out_byte, result.out_byte);
                if (result.error_code !== e.error_code)
                    $error("error_code exp %0d got %0d", e.error_code, result.error_code);
                if (result.message_end !== e.message_end)
                    $error("message_end exp %0d got %0d", e.message_end, result.message_end);
                if (result !== e)
                    fail_count++;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Directed datagrams: special cases, each row one datagram.
    typedef struct {
        logic [7:0] bytes[$];
        logic [2:0] kind_of_last;   // expected kind on the closing byte
        logic [2:0] err_of_last;
    } directed_row_t;

    directed_row_t directed[$];

    initial
    begin
        int base;
        coap_pkg::out_item_t tail;
        fail_count = 0;
        cycle_count = 0;
        sent_count = 0;
        push = 1'b0;
        data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        clear_parser();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            '{'{8'h00}, coap_pkg::KIND_ERROR, coap_pkg::ERR_VERSION},
            '{'{8'hC0, 8'h00}, coap_pkg::KIND_END, coap_pkg::ERR_NONE},
            '{'{8'h4F, 8'h00}, coap_pkg::KIND_END, coap_pkg::ERR_NONE},
            '{'{8'h40, 8'hFF, 8'hFF, 8'hFF}, coap_pkg::KIND_HEADER, coap_pkg::ERR_NONE},
            '{'{8'h78, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
                8'h05, 8'h06, 8'h07, 8'h08}, coap_pkg::KIND_TOKEN, coap_pkg::ERR_NONE},
            '{'{8'h40, 8'h01, 8'h00, 8'h00, 8'hFF},
              coap_pkg::KIND_ERROR, coap_pkg::ERR_TRUNCATED},
            '{'{8'h40, 8'h01, 8'h00, 8'h00, 8'hF0, 8'h00},
              coap_pkg::KIND_END, coap_pkg::ERR_NONE},
            '{'{8'h40, 8'h01, 8'h00, 8'h00, 8'h0F},
              coap_pkg::KIND_ERROR, coap_pkg::ERR_LENGTH},
            '{'{8'h40, 8'h01, 8'h00, 8'h00, 8'hEE, 8'hFF, 8'hFF},
              coap_pkg::KIND_ERROR, coap_pkg::ERR_LENGTH},
            '{'{8'h40, 8'h01, 8'h00, 8'h00, 8'h0E, 8'hFF, 8'hFF},
              coap_pkg::KIND_ERROR, coap_pkg::ERR_LENGTH},
            '{'{8'h40, 8'h01, 8'h00, 8'h00, 8'hD1, 8'hFF, 8'hAA},
              coap_pkg::KIND_OPTVAL, coap_pkg::ERR_NONE},
            '{'{8'h40, 8'h01, 8'h00, 8'h00, 8'h30, 8'hFF, 8'h55},
              coap_pkg::KIND_PAYLOAD, coap_pkg::ERR_NONE},
            '{'{8'h41, 8'h01, 8'h00, 8'h00}, coap_pkg::KIND_ERROR, coap_pkg::ERR_TRUNCATED},
            '{'{8'h40, 8'h01, 8'h00}, coap_pkg::KIND_ERROR, coap_pkg::ERR_TRUNCATED}
        };
        foreach (directed[i])
        begin
            send_list(directed[i].bytes);
            tail = expected_results[$];
            if (tail.item_kind !== directed[i].kind_of_last
                || tail.error_code !== directed[i].err_of_last)
            begin
                $error("row %0d predictor kind %0d err %0d", i, tail.item_kind,
                       tail.error_code);
                fail_count++;
            end
        end

        // random phases: receiver hold-off, sender idle, receiver stall, both
        base = sent_count;
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = (p == 1) ? 80 : (p == 3) ? 33 : 0;
            recv_stall_pct = (p == 2) ? 80 : (p == 3) ? 33 : 0;
            if (p == 0)
                hold_off = 1'b1;        // receiver holds off, block fills up
            while (sent_count < base + (p + 1) * PHASE_BYTES)
            begin
                send_random_datagram();
                if (p == 0 && hold_cycles >= 300)
                    hold_off = 1'b0;
            end
            hold_off = 1'b0;
            // sender pauses until the block is drained
            idle_sender();
            while (expected_results.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
